// ===== design/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared constants for the system control coprocessor: fixed id words,
// register addresses, reset values and status codes
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ADDR_W   = 14;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned FLAGS_W  = 4;

    typedef logic [ADDR_W-1:0] cp_addr_t;

    // {opc1, cn, cm, opc2}
    localparam cp_addr_t ADDR_MAIN_ID     = {3'd0, 4'd0,  4'd0, 3'd0};
    localparam cp_addr_t ADDR_CACHE_TYPE  = {3'd0, 4'd0,  4'd0, 3'd1};
    localparam cp_addr_t ADDR_CONTROL     = {3'd0, 4'd1,  4'd0, 3'd0};
    localparam cp_addr_t ADDR_WAIT_IRQ    = {3'd0, 4'd7,  4'd0, 3'd4};
    localparam cp_addr_t ADDR_ICACHE_ALL  = {3'd0, 4'd7,  4'd5, 3'd0};
    localparam cp_addr_t ADDR_ICACHE_LINE = {3'd0, 4'd7,  4'd5, 3'd1};
    localparam cp_addr_t ADDR_DTCM_REGION = {3'd0, 4'd9,  4'd1, 3'd0};
    localparam cp_addr_t ADDR_ITCM_REGION = {3'd0, 4'd9,  4'd1, 3'd1};
    localparam cp_addr_t ADDR_PROC_ID_A   = {3'd0, 4'd13, 4'd0, 3'd1};
    localparam cp_addr_t ADDR_PROC_ID_B   = {3'd0, 4'd13, 4'd1, 3'd1};

    localparam logic [WORD_W-1:0] MAIN_ID_WORD    = 32'h4105_9461;
    localparam logic [WORD_W-1:0] CACHE_TYPE_WORD = 32'h0F0D_2112;
    localparam logic [WORD_W-1:0] CONTROL_MASK    = 32'h000F_F085;
    localparam logic [WORD_W-1:0] CONTROL_FORCED  = 32'h0000_0078;
    localparam logic [WORD_W-1:0] REGION_BASE_MASK = 32'hFFFF_F000;
    localparam logic [WORD_W-1:0] LINE_MASK       = 32'hFFFF_FFE0;
    localparam logic [WORD_W-1:0] LINE_LAST       = 32'h0000_001F;

    localparam logic [WORD_W-1:0] CONTROL_RESET   = 32'h0005_707D;
    localparam logic [WORD_W-1:0] DTCM_WORD_RESET = 32'h0300_000A;
    localparam logic [WORD_W-1:0] ITCM_WORD_RESET = 32'h0000_0020;
    localparam logic [WORD_W-1:0] DTCM_BASE_RESET = 32'h0300_0000;
    localparam logic [WORD_W-1:0] DTCM_HIGH_RESET = 32'h0300_3FFF;
    localparam logic [WORD_W-1:0] ITCM_BASE_RESET = 32'h0000_0000;
    localparam logic [WORD_W-1:0] ITCM_HIGH_RESET = 32'h01FF_FFFF;

    // region size field limits, span is 2^(size+9) bytes
    localparam logic [4:0] REGION_SIZE_MIN = 5'd3;
    localparam logic [4:0] REGION_SIZE_MAX = 5'd23;
    localparam logic [4:0] REGION_SHIFT    = 5'd9;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNHANDLED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRAPS       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [KIND_W-1:0] INV_NONE = 2'd0;
    localparam logic [KIND_W-1:0] INV_ALL  = 2'd1;
    localparam logic [KIND_W-1:0] INV_LINE = 2'd2;

endpackage

// ===== design/system_control_coprocessor_top.sv =====
// ----------------------------------------------------------------------------
// system_control_coprocessor_top
// coprocessor register file for system control: id words, control, tcm regions
// ----------------------------------------------------------------------------
// usage:
//   one input transfer is one coprocessor access (func 0 read, 1 write),
//   addressed by opc1/cn/cm/opc2, with wdata for writes. each access gives
//   exactly one result transfer on the output channel.
//   path: the access is captured in an input register, decoded combinationally
//   and lands in the result register that drives the output channel.
//   throughput: one access per cycle unless stalled; register update and result
//   load share one clock edge, so the next access already sees the new state.
//   stall: while out_ready is low the result holds, the decode stage holds,
//   and in_ready drops once the input register is occupied too.
//   state-derived outputs (high_vectors, tcm ranges, tcm_flags) follow the
//   registers directly; they only change when a result is loaded, so they
//   stay stable while a result waits.
//   reset: asynchronous, active low; both stages empty, registers take
//   their boot defaults (dtcm at 0x03000000 for 16 KiB, itcm 32 MiB at 0).
// ----------------------------------------------------------------------------
module system_control_coprocessor_top (
    input  logic        clk,
    input  logic        rst_n,
    // access channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [2:0]  opc1,
    input  logic [3:0]  cn,
    input  logic [3:0]  cm,
    input  logic [2:0]  opc2,
    input  logic [31:0] wdata,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        high_vectors,
    output logic [31:0] dtcm_base,
    output logic [31:0] dtcm_high,
    output logic [31:0] itcm_base,
    output logic [31:0] itcm_high,
    output logic [3:0]  tcm_flags,
    output logic        wait_for_irq,
    output logic [1:0]  invalidate_kind,
    output logic [31:0] invalidate_low,
    output logic [31:0] invalidate_high,
    output logic [2:0]  status
);

    // input stage
    logic                  in_valid_reg;
    logic                  func_reg;
    scc_pkg::cp_addr_t     addr_reg;
    logic [31:0]           wdata_reg;

    // result stage
    logic                  out_valid_reg;
    logic [31:0]           read_data_reg,  read_data_next;
    logic                  wfi_reg,        wfi_next;
    logic [1:0]            kind_reg,       kind_next;
    logic [31:0]           inv_low_reg,    inv_low_next;
    logic [31:0]           inv_high_reg,   inv_high_next;
    logic [2:0]            status_reg,     status_next;

    // architectural registers
    logic [31:0]           control_reg,    control_next;
    logic [31:0]           dtcm_word_reg,  dtcm_word_next;
    logic [31:0]           itcm_word_reg,  itcm_word_next;
    logic [31:0]           proc_id_reg,    proc_id_next;
    logic [31:0]           dtcm_base_reg,  dtcm_base_next;
    logic [31:0]           dtcm_high_reg,  dtcm_high_next;
    logic [31:0]           itcm_base_reg,  itcm_base_next;
    logic [31:0]           itcm_high_reg,  itcm_high_next;

    // handshake
    logic                  advance;
    logic                  in_xfer;

    // region calculation
    logic [4:0]            region_size;
    logic                  size_bad;
    logic [31:0]           region_base;
    logic [32:0]           region_span;
    logic [32:0]           region_high;
    logic [2:0]            region_status;
    logic [31:0]           control_wr;
    logic [31:0]           line_low;

    // decode stage moves when it holds an access and the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // region word: size in bits 5..1, base on a 4 KiB boundary
    assign region_size   = wdata_reg[5:1];
    assign size_bad      = (region_size < scc_pkg::REGION_SIZE_MIN)
                        || (region_size > scc_pkg::REGION_SIZE_MAX);
    assign region_base   = wdata_reg & scc_pkg::REGION_BASE_MASK;
    // shift amount reaches 40 (32 for legal sizes), so it needs six bits
    assign region_span   = 33'(1) << ({1'b0, region_size} + 6'(scc_pkg::REGION_SHIFT));
    // top bit set means the region runs past the end of the address space
    assign region_high   = {1'b0, region_base} + region_span - 33'(1);
    assign region_status = size_bad        ? scc_pkg::ST_BAD_SIZE :
                           region_high[32] ? scc_pkg::ST_WRAPS    : scc_pkg::ST_OK;

    assign control_wr = (wdata_reg & scc_pkg::CONTROL_MASK) | scc_pkg::CONTROL_FORCED;
    assign line_low   = wdata_reg & scc_pkg::LINE_MASK;

    always_comb
    begin
        read_data_next = '0;
        wfi_next       = 1'b0;
        kind_next      = scc_pkg::INV_NONE;
        inv_low_next   = '0;
        inv_high_next  = '0;
        status_next    = scc_pkg::ST_OK;
        control_next   = control_reg;
        dtcm_word_next = dtcm_word_reg;
        itcm_word_next = itcm_word_reg;
        proc_id_next   = proc_id_reg;
        dtcm_base_next = dtcm_base_reg;
        dtcm_high_next = dtcm_high_reg;
        itcm_base_next = itcm_base_reg;
        itcm_high_next = itcm_high_reg;

        if (!func_reg)
        begin
            unique case (addr_reg)
                scc_pkg::ADDR_MAIN_ID:     read_data_next = scc_pkg::MAIN_ID_WORD;
                scc_pkg::ADDR_CACHE_TYPE:  read_data_next = scc_pkg::CACHE_TYPE_WORD;
                scc_pkg::ADDR_CONTROL:     read_data_next = control_reg;
                scc_pkg::ADDR_DTCM_REGION: read_data_next = dtcm_word_reg;
                scc_pkg::ADDR_ITCM_REGION: read_data_next = itcm_word_reg;
                scc_pkg::ADDR_PROC_ID_A,
                scc_pkg::ADDR_PROC_ID_B:   read_data_next = proc_id_reg;
                default:                   status_next    = scc_pkg::ST_UNHANDLED;
            endcase
        end
        else
        begin
            unique case (addr_reg)
                scc_pkg::ADDR_CONTROL:
                begin
                    control_next = control_wr;
                    // big-endian or armv4t mode: stored anyway, flagged
                    if (control_wr[7] || control_wr[15])
                        status_next = scc_pkg::ST_UNSUPPORTED;
                end
                scc_pkg::ADDR_WAIT_IRQ:    wfi_next  = 1'b1;
                scc_pkg::ADDR_ICACHE_ALL:  kind_next = scc_pkg::INV_ALL;
                scc_pkg::ADDR_ICACHE_LINE:
                begin
                    kind_next     = scc_pkg::INV_LINE;
                    inv_low_next  = line_low;
                    inv_high_next = line_low | scc_pkg::LINE_LAST;
                end
                scc_pkg::ADDR_DTCM_REGION:
                begin
                    status_next = region_status;
                    if (region_status == scc_pkg::ST_OK)
                    begin
                        dtcm_base_next = region_base;
                        dtcm_high_next = region_high[31:0];
                        dtcm_word_next = {wdata_reg[31:1], 1'b0};
                    end
                end
                scc_pkg::ADDR_ITCM_REGION:
                begin
                    status_next = region_status;
                    if (region_status == scc_pkg::ST_OK)
                    begin
                        itcm_base_next = region_base;
                        itcm_high_next = region_high[31:0];
                        itcm_word_next = {wdata_reg[31:1], 1'b0};
                    end
                end
                scc_pkg::ADDR_PROC_ID_A,
                scc_pkg::ADDR_PROC_ID_B:   proc_id_next = wdata_reg;
                default:                   status_next  = scc_pkg::ST_UNHANDLED;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            control_reg   <= scc_pkg::CONTROL_RESET;
            dtcm_word_reg <= scc_pkg::DTCM_WORD_RESET;
            itcm_word_reg <= scc_pkg::ITCM_WORD_RESET;
            proc_id_reg   <= '0;
            dtcm_base_reg <= scc_pkg::DTCM_BASE_RESET;
            dtcm_high_reg <= scc_pkg::DTCM_HIGH_RESET;
            itcm_base_reg <= scc_pkg::ITCM_BASE_RESET;
            itcm_high_reg <= scc_pkg::ITCM_HIGH_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            // registers change only as the access retires into the result slot
            if (advance)
            begin
                control_reg   <= control_next;
                dtcm_word_reg <= dtcm_word_next;
                itcm_word_reg <= itcm_word_next;
                proc_id_reg   <= proc_id_next;
                dtcm_base_reg <= dtcm_base_next;
                dtcm_high_reg <= dtcm_high_next;
                itcm_base_reg <= itcm_base_next;
                itcm_high_reg <= itcm_high_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= func;
            addr_reg  <= {opc1, cn, cm, opc2};
            wdata_reg <= wdata;
        end
        if (advance)
        begin
            read_data_reg <= read_data_next;
            wfi_reg       <= wfi_next;
            kind_reg      <= kind_next;
            inv_low_reg   <= inv_low_next;
            inv_high_reg  <= inv_high_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign wait_for_irq    = wfi_reg;
    assign invalidate_kind = kind_reg;
    assign invalidate_low  = inv_low_reg;
    assign invalidate_high = inv_high_reg;
    assign status          = status_reg;

    assign high_vectors = control_reg[13];
    assign dtcm_base    = dtcm_base_reg;
    assign dtcm_high    = dtcm_high_reg;
    assign itcm_base    = itcm_base_reg;
    assign itcm_high    = itcm_high_reg;
    // readable needs enable set and load mode clear
    assign tcm_flags    = {control_reg[18] && !control_reg[19], control_reg[18],
                           control_reg[16] && !control_reg[17], control_reg[16]};

endmodule

// ===== tb/system_control_coprocessor_top_tb.sv =====
// ----------------------------------------------------------------------------
// system_control_coprocessor_top_tb
// self-checking bench for the system control coprocessor: coprocessor reads
// and writes go in on the access channel, and every result transfer is
// compared field by field against an in-order prediction of the register file
// ----------------------------------------------------------------------------
module system_control_coprocessor_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // access direction
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // control register bit positions
    localparam int CTRL_BIG_ENDIAN = 7;
    localparam int CTRL_HIGH_VEC   = 13;
    localparam int CTRL_V4T        = 15;
    localparam int CTRL_DTCM_EN    = 16;
    localparam int CTRL_DTCM_LOAD  = 17;
    localparam int CTRL_ITCM_EN    = 18;
    localparam int CTRL_ITCM_LOAD  = 19;

    localparam int RANDOM_PER_PHASE = 485;   // four phases, plus the directed part
    localparam int HOLD_CYCLES      = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES     = 8;     // settling time before the verdict
    localparam int CYCLE_LIMIT      = 200000;

    // addresses the block decodes, used to aim most random accesses
    localparam scc_pkg::cp_addr_t KNOWN_ADDRS [10] = '{
        scc_pkg::ADDR_MAIN_ID, scc_pkg::ADDR_CACHE_TYPE, scc_pkg::ADDR_CONTROL,
        scc_pkg::ADDR_WAIT_IRQ, scc_pkg::ADDR_ICACHE_ALL, scc_pkg::ADDR_ICACHE_LINE,
        scc_pkg::ADDR_DTCM_REGION, scc_pkg::ADDR_ITCM_REGION, scc_pkg::ADDR_PROC_ID_A,
        scc_pkg::ADDR_PROC_ID_B
    };

    typedef struct packed {
        logic        func;
        logic [2:0]  opc1;
        logic [3:0]  cn;
        logic [3:0]  cm;
        logic [2:0]  opc2;
        logic [31:0] wdata;
    } access_t;

    typedef struct packed {
        logic [31:0]                  read_data;
        logic                         high_vectors;
        logic [31:0]                  dtcm_base;
        logic [31:0]                  dtcm_high;
        logic [31:0]                  itcm_base;
        logic [31:0]                  itcm_high;
        logic [scc_pkg::FLAGS_W-1:0]  tcm_flags;
        logic                         wait_for_irq;
        logic [scc_pkg::KIND_W-1:0]   invalidate_kind;
        logic [31:0]                  invalidate_low;
        logic [31:0]                  invalidate_high;
        logic [scc_pkg::STATUS_W-1:0] status;
    } result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        func      = 1'b0;
    logic [2:0]  opc1      = '0;
    logic [3:0]  cn        = '0;
    logic [3:0]  cm        = '0;
    logic [2:0]  opc2      = '0;
    logic [31:0] wdata     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic        high_vectors;
    logic [31:0] dtcm_base;
    logic [31:0] dtcm_high;
    logic [31:0] itcm_base;
    logic [31:0] itcm_high;
    logic [3:0]  tcm_flags;
    logic        wait_for_irq;
    logic [1:0]  invalidate_kind;
    logic [31:0] invalidate_low;
    logic [31:0] invalidate_high;
    logic [2:0]  status;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    system_control_coprocessor_top i_dut (.*);

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    access_t     access_q [$];      // accesses waiting to be offered
    result_t     result_q [$];      // predicted results, oldest first
    int unsigned error_count     = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    logic        hold_request    = 1'b0;
    logic        hold_done       = 1'b0;
    int unsigned hold_left       = 0;
    int unsigned cycle_count     = 0;

    // predicted copy of the coprocessor registers
    logic [31:0] ctrl_word   = scc_pkg::CONTROL_RESET;
    logic [31:0] dtcm_word   = scc_pkg::DTCM_WORD_RESET;
    logic [31:0] itcm_word   = scc_pkg::ITCM_WORD_RESET;
    logic [31:0] proc_id     = '0;
    logic [31:0] dtcm_lo     = scc_pkg::DTCM_BASE_RESET;
    logic [31:0] dtcm_hi     = scc_pkg::DTCM_HIGH_RESET;
    logic [31:0] itcm_lo     = scc_pkg::ITCM_BASE_RESET;
    logic [31:0] itcm_hi     = scc_pkg::ITCM_HIGH_RESET;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // tcm window from a region word; span is 2^(size+9), checked on 33 bits
    function automatic logic [scc_pkg::STATUS_W-1:0] region_span(
        input  logic [31:0] v,
        output logic [31:0] lo,
        output logic [31:0] hi);
        logic [4:0]  size;
        int unsigned shift;
        logic [32:0] top;
        size = v[5:1];
        lo   = v & scc_pkg::REGION_BASE_MASK;
        hi   = '0;
        if (size < scc_pkg::REGION_SIZE_MIN || size > scc_pkg::REGION_SIZE_MAX)
            return scc_pkg::ST_BAD_SIZE;
        shift = 32'(size) + 32'(scc_pkg::REGION_SHIFT);
        top   = {1'b0, lo} + (33'd1 << shift) - 33'd1;
        hi    = top[31:0];
        if (top[32])
            return scc_pkg::ST_WRAPS;
        return scc_pkg::ST_OK;
    endfunction

    // applies one access to the predicted registers and returns its result
    function automatic result_t predict_access(access_t a);
        result_t                      r;
        scc_pkg::cp_addr_t            addr;
        logic [scc_pkg::STATUS_W-1:0] st;
        logic [31:0]                  lo;
        logic [31:0]                  hi;
        addr = {a.opc1, a.cn, a.cm, a.opc2};
        r    = '0;
        st   = scc_pkg::ST_OK;
        if (a.func == FUNC_READ)
        begin
            case (addr)
                scc_pkg::ADDR_MAIN_ID:     r.read_data = scc_pkg::MAIN_ID_WORD;
                scc_pkg::ADDR_CACHE_TYPE:  r.read_data = scc_pkg::CACHE_TYPE_WORD;
                scc_pkg::ADDR_CONTROL:     r.read_data = ctrl_word;
                scc_pkg::ADDR_DTCM_REGION: r.read_data = dtcm_word;
                scc_pkg::ADDR_ITCM_REGION: r.read_data = itcm_word;
                scc_pkg::ADDR_PROC_ID_A,
                scc_pkg::ADDR_PROC_ID_B:   r.read_data = proc_id;
                default:                   st = scc_pkg::ST_UNHANDLED;
            endcase
        end
        else
        begin
            case (addr)
                scc_pkg::ADDR_CONTROL:
                begin
                    // stored and applied even when the mode is unsupported
                    ctrl_word = (a.wdata & scc_pkg::CONTROL_MASK) | scc_pkg::CONTROL_FORCED;
                    if (ctrl_word[CTRL_BIG_ENDIAN] || ctrl_word[CTRL_V4T])
                        st = scc_pkg::ST_UNSUPPORTED;
                end
                scc_pkg::ADDR_WAIT_IRQ:   r.wait_for_irq = 1'b1;
                scc_pkg::ADDR_ICACHE_ALL: r.invalidate_kind = scc_pkg::INV_ALL;
                scc_pkg::ADDR_ICACHE_LINE:
                begin
                    r.invalidate_kind = scc_pkg::INV_LINE;
                    r.invalidate_low  = a.wdata & scc_pkg::LINE_MASK;
                    r.invalidate_high = r.invalidate_low + scc_pkg::LINE_LAST;
                end
                scc_pkg::ADDR_DTCM_REGION:
                begin
                    st = region_span(a.wdata, lo, hi);
                    if (st == scc_pkg::ST_OK)
                    begin
                        dtcm_lo   = lo;
                        dtcm_hi   = hi;
                        dtcm_word = {a.wdata[31:1], 1'b0};
                    end
                end
                scc_pkg::ADDR_ITCM_REGION:
                begin
                    st = region_span(a.wdata, lo, hi);
                    if (st == scc_pkg::ST_OK)
                    begin
                        itcm_lo   = lo;
                        itcm_hi   = hi;
                        itcm_word = {a.wdata[31:1], 1'b0};
                    end
                end
                scc_pkg::ADDR_PROC_ID_A,
                scc_pkg::ADDR_PROC_ID_B: proc_id = a.wdata;
                default: st = scc_pkg::ST_UNHANDLED;
            endcase
        end
        // state-derived fields show the registers after this access
        r.status       = st;
        r.high_vectors = ctrl_word[CTRL_HIGH_VEC];
        r.dtcm_base    = dtcm_lo;
        r.dtcm_high    = dtcm_hi;
        r.itcm_base    = itcm_lo;
        r.itcm_high    = itcm_hi;
        r.tcm_flags    = {ctrl_word[CTRL_ITCM_EN] & ~ctrl_word[CTRL_ITCM_LOAD],
                          ctrl_word[CTRL_ITCM_EN],
                          ctrl_word[CTRL_DTCM_EN] & ~ctrl_word[CTRL_DTCM_LOAD],
                          ctrl_word[CTRL_DTCM_EN]};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_access(logic f, scc_pkg::cp_addr_t addr, logic [31:0] w);
        access_t a;
        a.func = f;
        {a.opc1, a.cn, a.cm, a.opc2} = addr;
        a.wdata = w;
        access_q.push_back(a);
    endfunction

    // mostly decoded addresses with shaped data, the rest raw noise
    function automatic access_t random_access();
        access_t           a;
        scc_pkg::cp_addr_t addr;
        logic [4:0]        size;
        logic [31:0]       base;
        a.func  = 1'($urandom_range(0, 1));
        a.wdata = $urandom;
        {a.opc1, a.cn, a.cm, a.opc2} = scc_pkg::cp_addr_t'($urandom);
        if ($urandom_range(0, 99) < 65)
        begin
            addr = KNOWN_ADDRS[$urandom_range(0, 9)];
            {a.opc1, a.cn, a.cm, a.opc2} = addr;
            if ((addr == scc_pkg::ADDR_DTCM_REGION || addr == scc_pkg::ADDR_ITCM_REGION)
                && $urandom_range(0, 99) < 80)
            begin
                // sizes mostly legal, bases often low so big windows still fit
                size = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(3, 23))
                                                    : 5'($urandom_range(0, 31));
                base = $urandom >> $urandom_range(0, 24);
                a.wdata = {base[31:12], a.wdata[11:6], size, a.wdata[0]};
            end
            else if (addr == scc_pkg::ADDR_CONTROL && $urandom_range(0, 1) == 1)
            begin
                a.wdata[CTRL_BIG_ENDIAN] = 1'b0;
                a.wdata[CTRL_V4T]        = 1'b0;
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // access driver: predicts on every transfer, then offers the next access
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : access_driver
        access_t offered;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                result_q.push_back(predict_access(offered));
            // the slot is free unless an access is still waiting for in_ready
            if (!in_valid || in_ready)
            begin
                if (access_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offered  = access_q.pop_front();
                    func     <= offered.func;
                    opc1     <= offered.opc1;
                    cn       <= offered.cn;
                    cm       <= offered.cm;
                    opc2     <= offered.opc2;
                    wdata    <= offered.wdata;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted here so the block fills and stalls input
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each transfer against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result transfer, read_data %h status %0d",
                             $time, read_data, status);
                    error_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("high_vectors", 32'(want.high_vectors), 32'(high_vectors));
                    check_field("dtcm_base", want.dtcm_base, dtcm_base);
                    check_field("dtcm_high", want.dtcm_high, dtcm_high);
                    check_field("itcm_base", want.itcm_base, itcm_base);
                    check_field("itcm_high", want.itcm_high, itcm_high);
                    check_field("tcm_flags", 32'(want.tcm_flags), 32'(tcm_flags));
                    check_field("wait_for_irq", 32'(want.wait_for_irq), 32'(wait_for_irq));
                    check_field("invalidate_kind", 32'(want.invalidate_kind),
                                32'(invalidate_kind));
                    check_field("invalidate_low", want.invalidate_low, invalidate_low);
                    check_field("invalidate_high", want.invalidate_high, invalidate_high);
                    check_field("status", 32'(want.status), 32'(status));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout with %0d results outstanding", $time, result_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: directed accesses, then random accesses over four idling phases
    // ------------------------------------------------------------------------
    initial
    begin
        // id words and boot values of every readable register
        push_access(FUNC_READ,  scc_pkg::ADDR_MAIN_ID,     '0);
        push_access(FUNC_READ,  scc_pkg::ADDR_CACHE_TYPE,  '0);
        push_access(FUNC_READ,  scc_pkg::ADDR_CONTROL,     '0);
        push_access(FUNC_READ,  scc_pkg::ADDR_DTCM_REGION, '0);
        push_access(FUNC_READ,  scc_pkg::ADDR_ITCM_REGION, '0);
        push_access(FUNC_READ,  scc_pkg::ADDR_PROC_ID_A,   '0);
        // process id shared by both aliases
        push_access(FUNC_WRITE, scc_pkg::ADDR_PROC_ID_B,   32'hFFFF_FFFF);
        push_access(FUNC_READ,  scc_pkg::ADDR_PROC_ID_A,   '0);
        // control: all ones (big-endian and v4t, load modes), clean enable,
        // v4t alone, all zeros
        push_access(FUNC_WRITE, scc_pkg::ADDR_CONTROL,     32'hFFFF_FFFF);
        push_access(FUNC_WRITE, scc_pkg::ADDR_CONTROL,     32'h0005_2000);
        push_access(FUNC_WRITE, scc_pkg::ADDR_CONTROL,     32'h0000_8000);
        push_access(FUNC_WRITE, scc_pkg::ADDR_CONTROL,     32'h0000_0000);
        // side-signal writes, line invalidate at the top of the address space
        push_access(FUNC_WRITE, scc_pkg::ADDR_WAIT_IRQ,    $urandom);
        push_access(FUNC_WRITE, scc_pkg::ADDR_ICACHE_ALL,  $urandom);
        push_access(FUNC_WRITE, scc_pkg::ADDR_ICACHE_LINE, 32'hFFFF_FFFF);
        // region sizes just outside the legal range
        push_access(FUNC_WRITE, scc_pkg::ADDR_DTCM_REGION, 32'h0123_4004);
        push_access(FUNC_WRITE, scc_pkg::ADDR_DTCM_REGION, 32'h0123_4030);
        // smallest window ending exactly at the top, bit 0 set on the way in
        push_access(FUNC_WRITE, scc_pkg::ADDR_DTCM_REGION, 32'hFFFF_F007);
        push_access(FUNC_READ,  scc_pkg::ADDR_DTCM_REGION, '0);
        // largest window at zero fits, one page up it wraps
        push_access(FUNC_WRITE, scc_pkg::ADDR_ITCM_REGION, 32'h0000_002E);
        push_access(FUNC_WRITE, scc_pkg::ADDR_ITCM_REGION, 32'h0000_102E);
        push_access(FUNC_READ,  scc_pkg::ADDR_ITCM_REGION, '0);
        // unhandled: read of a c7 operation, write to an id word, opc1 nonzero
        push_access(FUNC_READ,  scc_pkg::ADDR_ICACHE_LINE, '0);
        push_access(FUNC_WRITE, scc_pkg::ADDR_MAIN_ID,     $urandom);
        push_access(FUNC_READ,  scc_pkg::cp_addr_t'({3'd7, 4'd1, 4'd0, 3'd0}), '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    // no idling, with the long hold-off up front
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                    hold_request    <= 1'b1;
                end
                1:
                begin
                    sender_idle_pct <= 77;
                    recv_stall_pct  <= 0;
                end
                2:
                begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 77;
                end
                default:
                begin
                    sender_idle_pct <= 12;
                    recv_stall_pct  <= 12;
                end
            endcase
            repeat (RANDOM_PER_PHASE) access_q.push_back(random_access());
            // sampled at the falling edge, clear of the clocked processes
            do
                @(negedge clk);
            while (access_q.size() != 0 || in_valid || result_q.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/scc_pkg.sv
design/system_control_coprocessor_top.sv
tb/system_control_coprocessor_top_tb.sv
